>>> rtl/ela_pkg.sv
// Shared types and constants for the edge list to adjacency builder.
// Item layouts of the input, result and configuration channels.
// No dependencies.
package ela_pkg;

  localparam int NODE_W  = 6;
  localparam int DEG_W   = 7;
  localparam int DROP_W  = 8;
  localparam int NCNT_W  = 7;
  localparam int EDGE_W  = 2 * NODE_W;

  localparam logic [DROP_W-1:0] DROP_MAX       = '1;
  localparam logic [NCNT_W-1:0] NODE_COUNT_RST = 7'd64;

  typedef struct packed {
    logic [NODE_W-1:0] first_node;
    logic [NODE_W-1:0] second_node;
    logic              last_edge;
  } in_item_t;

  typedef struct packed {
    logic [NODE_W-1:0] owner_node;
    logic [NODE_W-1:0] slot;
    logic [NODE_W-1:0] neighbour;
    logic [DEG_W-1:0]  owner_degree;
    logic              empty_graph;
    logic [DROP_W-1:0] dropped_edges;
    logic              last_result;
  } out_item_t;

  typedef struct packed {
    logic [NCNT_W-1:0] node_count;
  } cfg_item_t;

endpackage

>>> rtl/ela_chan_if.sv
// Valid/ready channel carrying one item of a given type.
// Item types come from ela_pkg at the point of instantiation.
interface ela_chan_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/edge_list_to_adjacency_build.sv
// Edge list to packed adjacency builder, top level.
// Depends on ela_pkg and ela_chan_if.
//
// Channels: in_chan takes one undirected edge per item, last_edge marks the
// end of a list. out_chan gives one item per slot of the packed adjacency
// array, in slot order, or a single empty marker when no edge was stored.
// cfg_chan writes node_count; it is always ready. Write it only while the
// block is idle; the block itself does not enforce this.
// Load: a stored edge is written to the edge store, then each endpoint's
// degree in the node memory gets a read-modify-write (one write adding two
// for a self-loop); a dropped edge is only counted. The input is not ready
// again until the degree updates are done. Build after the last edge: a
// start-slot sum over all nodes, a scatter of each stored edge (two
// dependent read-modify-writes of the fill pointers), then the emit, which
// reads each node's degree and then its slots, and also clears each degree.
// Reset: a clearing pass over all MAX_NODES entries zeroes the node memory;
// the input is not ready meanwhile, configuration writes are taken.
// A stalled receiver holds the emit; the input is taken again once the emit
// has passed the last node, even if the final result is not yet taken.
module edge_list_to_adjacency_build
  import ela_pkg::*;
#(
  parameter int MAX_NODES = 64,
  parameter int MAX_EDGES = 32
) (
  input logic         clk,
  input logic         rst_n,
  ela_chan_if.sink    in_chan,
  ela_chan_if.source  out_chan,
  ela_chan_if.sink    cfg_chan
);

  localparam int NS     = 2 * MAX_EDGES;
  localparam int NI_W   = $clog2(MAX_NODES);
  localparam int ET_W   = $clog2(MAX_EDGES + 1);
  localparam int EI_W   = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int SI_W   = $clog2(NS);
  localparam int RUN_W  = $clog2(MAX_NODES * 128 + 1);
  localparam int CMP_W  = ((RUN_W > ET_W) ? RUN_W : ET_W) + 2;

  localparam logic [NI_W-1:0] LAST_NODE = NI_W'(MAX_NODES - 1);

  localparam logic [3:0] S_CLEAR  = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_INC_A  = 4'd2;
  localparam logic [3:0] S_INC_B  = 4'd3;
  localparam logic [3:0] S_PRE_RD = 4'd4;
  localparam logic [3:0] S_PRE_WR = 4'd5;
  localparam logic [3:0] S_SC_E   = 4'd6;
  localparam logic [3:0] S_SC_A0  = 4'd7;
  localparam logic [3:0] S_SC_A1  = 4'd8;
  localparam logic [3:0] S_SC_B0  = 4'd9;
  localparam logic [3:0] S_SC_B1  = 4'd10;
  localparam logic [3:0] S_EM_RD  = 4'd11;
  localparam logic [3:0] S_EM_DEG = 4'd12;
  localparam logic [3:0] S_EM_NB  = 4'd13;
  localparam logic [3:0] S_EM_OUT = 4'd14;
  localparam logic [3:0] S_EMPTY  = 4'd15;

  typedef struct packed {
    logic [DEG_W-1:0] deg;
    logic [RUN_W-1:0] fill;
  } nent_t;

  // memories
  nent_t               node_mem [MAX_NODES];
  logic [EDGE_W-1:0]   edge_mem [MAX_EDGES];
  logic [NODE_W-1:0]   nbr_mem  [NS];

  nent_t               node_rd_r;
  logic [EDGE_W-1:0]   edge_rd_r;
  logic [NODE_W-1:0]   nbr_rd_r;

  logic                node_we, node_re;
  logic [NI_W-1:0]     node_waddr, node_raddr;
  nent_t               node_wdata;
  logic                edge_we, edge_re;
  logic [EI_W-1:0]     edge_waddr, edge_raddr;
  logic [EDGE_W-1:0]   edge_wdata;
  logic                nbr_we, nbr_re;
  logic [SI_W-1:0]     nbr_waddr, nbr_raddr;
  logic [NODE_W-1:0]   nbr_wdata;

  // control state
  logic [3:0]          state_r, state_nxt;
  logic [ET_W-1:0]     total_r, total_nxt;
  logic [DROP_W-1:0]   drop_r, drop_nxt;
  logic                last_r, last_nxt;
  logic [NODE_W-1:0]   ea_r, ea_nxt, eb_r, eb_nxt;
  logic [NI_W-1:0]     idx_r, idx_nxt;
  logic [ET_W-1:0]     eidx_r, eidx_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;
  logic [RUN_W-1:0]    slot_r, slot_nxt;
  logic [DEG_W-1:0]    deg_r, deg_nxt;
  logic [DEG_W-1:0]    cnt_r, cnt_nxt;
  logic [NCNT_W-1:0]   node_count_r;
  logic                out_valid_r;
  out_item_t           out_item_r, out_item_nxt;
  logic                out_load;

  logic                in_ready, in_fire, out_free, edge_ok;
  logic [ET_W-1:0]     eidx_inc;
  logic [DEG_W-1:0]    cnt_inc;

  assign in_ready      = (state_r == S_IDLE);
  assign in_chan.ready = in_ready;
  assign in_fire       = in_chan.valid && in_ready;
  assign out_free      = !out_valid_r || out_chan.ready;
  assign cfg_chan.ready = 1'b1;
  assign out_chan.valid = out_valid_r;
  assign out_chan.data  = out_item_r;
  assign eidx_inc      = eidx_r + ET_W'(1);
  assign cnt_inc       = cnt_r + DEG_W'(1);

  assign edge_ok = ({1'b0, in_chan.data.first_node} < node_count_r)
                && ({1'b0, in_chan.data.second_node} < node_count_r)
                && (32'(in_chan.data.first_node) < MAX_NODES)
                && (32'(in_chan.data.second_node) < MAX_NODES)
                && (total_r < ET_W'(MAX_EDGES));

  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    drop_nxt     = drop_r;
    last_nxt     = last_r;
    ea_nxt       = ea_r;
    eb_nxt       = eb_r;
    idx_nxt      = idx_r;
    eidx_nxt     = eidx_r;
    run_nxt      = run_r;
    slot_nxt     = slot_r;
    deg_nxt      = deg_r;
    cnt_nxt      = cnt_r;
    node_we      = 1'b0;
    node_re      = 1'b0;
    node_waddr   = idx_r;
    node_raddr   = idx_r;
    node_wdata   = '0;
    edge_we      = 1'b0;
    edge_re      = 1'b0;
    edge_waddr   = total_r[EI_W-1:0];
    edge_raddr   = eidx_r[EI_W-1:0];
    edge_wdata   = {in_chan.data.first_node, in_chan.data.second_node};
    nbr_we       = 1'b0;
    nbr_re       = 1'b0;
    nbr_waddr    = node_rd_r.fill[SI_W-1:0];
    nbr_raddr    = slot_r[SI_W-1:0];
    nbr_wdata    = eb_r;
    out_load     = 1'b0;
    out_item_nxt = '0;

    unique case (state_r)
      S_CLEAR: begin
        node_we = 1'b1;
        if (idx_r == LAST_NODE) begin
          state_nxt = S_IDLE;
        end else begin
          idx_nxt = idx_r + NI_W'(1);
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          last_nxt = in_chan.data.last_edge;
          ea_nxt   = in_chan.data.first_node;
          eb_nxt   = in_chan.data.second_node;
          if (edge_ok) begin
            edge_we    = 1'b1;
            total_nxt  = total_r + ET_W'(1);
            node_re    = 1'b1;
            node_raddr = NI_W'(in_chan.data.first_node);
            state_nxt  = S_INC_A;
          end else begin
            if (drop_r != DROP_MAX) begin
              drop_nxt = drop_r + DROP_W'(1);
            end
            if (in_chan.data.last_edge) begin
              idx_nxt   = '0;
              run_nxt   = '0;
              state_nxt = (total_r == '0) ? S_EMPTY : S_PRE_RD;
            end
          end
        end
      end
      S_INC_A: begin
        node_we         = 1'b1;
        node_waddr      = NI_W'(ea_r);
        node_wdata.fill = node_rd_r.fill;
        if (ea_r == eb_r) begin
          node_wdata.deg = node_rd_r.deg + DEG_W'(2);
          idx_nxt        = '0;
          run_nxt        = '0;
          state_nxt      = last_r ? S_PRE_RD : S_IDLE;
        end else begin
          node_wdata.deg = node_rd_r.deg + DEG_W'(1);
          node_re        = 1'b1;
          node_raddr     = NI_W'(eb_r);
          state_nxt      = S_INC_B;
        end
      end
      S_INC_B: begin
        node_we         = 1'b1;
        node_waddr      = NI_W'(eb_r);
        node_wdata.fill = node_rd_r.fill;
        node_wdata.deg  = node_rd_r.deg + DEG_W'(1);
        idx_nxt         = '0;
        run_nxt         = '0;
        state_nxt       = last_r ? S_PRE_RD : S_IDLE;
      end
      S_PRE_RD: begin
        node_re   = 1'b1;
        state_nxt = S_PRE_WR;
      end
      S_PRE_WR: begin
        node_we         = 1'b1;
        node_wdata.deg  = node_rd_r.deg;
        node_wdata.fill = run_r;
        run_nxt         = run_r + RUN_W'(node_rd_r.deg);
        if (idx_r == LAST_NODE) begin
          eidx_nxt  = '0;
          state_nxt = S_SC_E;
        end else begin
          idx_nxt   = idx_r + NI_W'(1);
          state_nxt = S_PRE_RD;
        end
      end
      S_SC_E: begin
        edge_re   = 1'b1;
        state_nxt = S_SC_A0;
      end
      S_SC_A0: begin
        ea_nxt     = edge_rd_r[EDGE_W-1:NODE_W];
        eb_nxt     = edge_rd_r[NODE_W-1:0];
        node_re    = 1'b1;
        node_raddr = NI_W'(edge_rd_r[EDGE_W-1:NODE_W]);
        state_nxt  = S_SC_A1;
      end
      S_SC_A1: begin
        if (32'(node_rd_r.fill) < NS) begin
          nbr_we          = 1'b1;
          nbr_wdata       = eb_r;
          node_we         = 1'b1;
          node_waddr      = NI_W'(ea_r);
          node_wdata.deg  = node_rd_r.deg;
          node_wdata.fill = node_rd_r.fill + RUN_W'(1);
        end
        state_nxt = S_SC_B0;
      end
      S_SC_B0: begin
        node_re    = 1'b1;
        node_raddr = NI_W'(eb_r);
        state_nxt  = S_SC_B1;
      end
      S_SC_B1: begin
        if (32'(node_rd_r.fill) < NS) begin
          nbr_we          = 1'b1;
          nbr_wdata       = ea_r;
          node_we         = 1'b1;
          node_waddr      = NI_W'(eb_r);
          node_wdata.deg  = node_rd_r.deg;
          node_wdata.fill = node_rd_r.fill + RUN_W'(1);
        end
        eidx_nxt = eidx_inc;
        if (eidx_inc == total_r) begin
          idx_nxt   = '0;
          run_nxt   = '0;
          state_nxt = S_EM_RD;
        end else begin
          state_nxt = S_SC_E;
        end
      end
      S_EM_RD: begin
        node_re   = 1'b1;
        state_nxt = S_EM_DEG;
      end
      S_EM_DEG: begin
        deg_nxt  = node_rd_r.deg;
        node_we  = 1'b1;
        cnt_nxt  = '0;
        slot_nxt = run_r;
        if (node_rd_r.deg == '0) begin
          if (idx_r == LAST_NODE) begin
            total_nxt = '0;
            drop_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + NI_W'(1);
            state_nxt = S_EM_RD;
          end
        end else begin
          state_nxt = S_EM_NB;
        end
      end
      S_EM_NB: begin
        if (32'(slot_r) >= NS) begin
          run_nxt = run_r + RUN_W'(deg_r);
          if (idx_r == LAST_NODE) begin
            total_nxt = '0;
            drop_nxt  = '0;
            state_nxt = S_IDLE;
          end else begin
            idx_nxt   = idx_r + NI_W'(1);
            state_nxt = S_EM_RD;
          end
        end else begin
          nbr_re    = 1'b1;
          state_nxt = S_EM_OUT;
        end
      end
      S_EM_OUT: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_item_nxt.owner_node    = NODE_W'(idx_r);
          out_item_nxt.slot          = NODE_W'(slot_r);
          out_item_nxt.neighbour     = nbr_rd_r;
          out_item_nxt.owner_degree  = deg_r;
          out_item_nxt.dropped_edges = drop_r;
          out_item_nxt.last_result   =
            (CMP_W'(slot_r) + CMP_W'(1)) == (CMP_W'(total_r) << 1);
          cnt_nxt  = cnt_inc;
          slot_nxt = slot_r + RUN_W'(1);
          if (cnt_inc == deg_r) begin
            run_nxt = run_r + RUN_W'(deg_r);
            if (idx_r == LAST_NODE) begin
              total_nxt = '0;
              drop_nxt  = '0;
              state_nxt = S_IDLE;
            end else begin
              idx_nxt   = idx_r + NI_W'(1);
              state_nxt = S_EM_RD;
            end
          end else begin
            state_nxt = S_EM_NB;
          end
        end
      end
      S_EMPTY: begin
        if (out_free) begin
          out_load                   = 1'b1;
          out_item_nxt.empty_graph   = 1'b1;
          out_item_nxt.dropped_edges = drop_r;
          out_item_nxt.last_result   = 1'b1;
          total_nxt                  = '0;
          drop_nxt                   = '0;
          state_nxt                  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (node_we) begin
      node_mem[node_waddr] <= node_wdata;
    end
    if (node_re) begin
      node_rd_r <= node_mem[node_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (edge_we) begin
      edge_mem[edge_waddr] <= edge_wdata;
    end
    if (edge_re) begin
      edge_rd_r <= edge_mem[edge_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (nbr_we) begin
      nbr_mem[nbr_waddr] <= nbr_wdata;
    end
    if (nbr_re) begin
      nbr_rd_r <= nbr_mem[nbr_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      total_r      <= '0;
      drop_r       <= '0;
      last_r       <= 1'b0;
      idx_r        <= '0;
      eidx_r       <= '0;
      run_r        <= '0;
      cnt_r        <= '0;
      node_count_r <= NODE_COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      total_r <= total_nxt;
      drop_r  <= drop_nxt;
      last_r  <= last_nxt;
      idx_r   <= idx_nxt;
      eidx_r  <= eidx_nxt;
      run_r   <= run_nxt;
      cnt_r   <= cnt_nxt;
      if (cfg_chan.valid) begin
        node_count_r <= cfg_chan.data.node_count;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    ea_r   <= ea_nxt;
    eb_r   <= eb_nxt;
    slot_r <= slot_nxt;
    deg_r  <= deg_nxt;
    if (out_load) begin
      out_item_r <= out_item_nxt;
    end
  end

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= ET_W'(MAX_EDGES))
    else $error("edge total beyond capacity");

  a_load_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> (state_r == S_EM_OUT || state_r == S_EMPTY))
    else $error("result loaded outside the emit");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> out_free)
    else $error("output register overwritten while held");

  a_store_inc: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && edge_ok) |=> (state_r == S_INC_A))
    else $error("stored edge without degree update");

  a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && out_item_nxt.empty_graph) |->
      (out_item_nxt.last_result && total_r == '0))
    else $error("empty marker with edges stored");

endmodule
